[design/pdrt_pkg.sv]
// Shared constants, types and the derivative table for the perceptron trainer.
// Used by pdrt_weights and perceptron_delta_rule_trainer_top; no dependencies.
package pdrt_pkg;

  localparam int INPUT_BITS  = 4;
  localparam int WEIGHT_BITS = 16;
  localparam int DERIV_DEPTH = 256;

  localparam int NUM_WEIGHTS = INPUT_BITS + 1;               // inputs plus bias
  localparam int NET_BITS    = WEIGHT_BITS + $clog2(NUM_WEIGHTS);
  localparam int IDX_BITS    = $clog2(DERIV_DEPTH);
  localparam int IDX_SHIFT   = 4;                            // table step is 1/16 of net
  localparam int ENTRY_BITS  = 16;                           // unsigned Q0.16
  localparam int LR_BITS     = 12;                           // unsigned Q4.8
  localparam int EPOCH_BITS  = 6;
  localparam int ERR_BITS    = 8;
  localparam int STAT_BITS   = 2;
  localparam int OP_BITS     = 2;
  localparam int FRAC_SHIFT  = 16;
  localparam int PROD_BITS   = LR_BITS + ENTRY_BITS;
  localparam int STEP_BITS   = PROD_BITS + 1 - FRAC_SHIFT;
  localparam int ACC_BITS    = ((WEIGHT_BITS > STEP_BITS) ? WEIGHT_BITS : STEP_BITS) + 2;

  localparam logic [OP_BITS-1:0] OP_TRAIN    = OP_BITS'(0);
  localparam logic [OP_BITS-1:0] OP_CLASSIFY = OP_BITS'(1);
  localparam logic [OP_BITS-1:0] OP_CLEAR    = OP_BITS'(2);

  localparam logic [STAT_BITS-1:0] STAT_RUNNING   = STAT_BITS'(0);
  localparam logic [STAT_BITS-1:0] STAT_CONVERGED = STAT_BITS'(1);
  localparam logic [STAT_BITS-1:0] STAT_GAVE_UP   = STAT_BITS'(2);

  localparam logic [0:0] CFG_LEARNING_RATE = 1'b0;
  localparam logic [0:0] CFG_MAX_EPOCHS    = 1'b1;

  localparam logic [LR_BITS-1:0]    LR_RESET     = LR_BITS'(256);
  localparam logic [EPOCH_BITS-1:0] EPOCHS_RESET = EPOCH_BITS'(40);

  typedef logic [DERIV_DEPTH-1:0][ENTRY_BITS-1:0] deriv_rom_t;

  // Weight update request from the update stage to the weight bank
  typedef struct packed {
    logic                  apply;
    logic                  clear;
    logic                  increase;
    logic [INPUT_BITS-1:0] pattern;
    logic [STEP_BITS-1:0]  step;
  } wupd_t;

  // 0.5*sech^2(i/16) in Q0.16, built from a Q0.16 exp(-2x) recurrence.
  // Evaluated at elaboration only; the quotient is a shift-subtract loop.
  function automatic deriv_rom_t build_deriv_rom();
    deriv_rom_t  rom;
    logic [63:0] r;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] rem;
    logic [63:0] quo;
    rom = '0;
    r   = 64'd65536;
    for (int i = 0; i < DERIV_DEPTH; i++) begin
      den = (64'd65536 + r) * (64'd65536 + r);
      num = (r << 1) << 32;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= den) begin
          rem    = rem - den;
          quo[b] = 1'b1;
        end
      end
      rom[i] = quo[ENTRY_BITS-1:0];
      r = (r * 64'd57835 + 64'd32768) >> 16;
    end
    return rom;
  endfunction

  localparam deriv_rom_t DERIV_ROM = build_deriv_rom();

endpackage

[design/perceptron_delta_rule_trainer_top.sv]
// Top level of the perceptron delta-rule trainer: stream ports, pipeline,
// derivative lookup, step multiplier and epoch counters. Depends on pdrt_pkg, pdrt_weights.
//
// One neuron with four binary inputs and a bias is trained on a request stream.
// Each request carries op (train, classify or clear), a pattern, a target and
// tlast marking the final training sample of an epoch; each request yields one
// result. Requests pass through three registers: an input register, a lookup
// stage (net sum, sign, derivative table read) and an update stage (rate times
// derivative, saturating weight update, error and epoch counters) that loads
// the output register. Classify requests, and train requests that match their
// target, move one per cycle while results are taken. A request that changes
// the weights (a mismatching train request while training runs, or a clear)
// holds the next request in the input register until it has left the lookup
// stage register, as the next net sum needs the updated weights. A result
// passes the input, lookup stage and output registers. The output register
// parts the two stream sides, so requests keep entering while a result waits,
// until the input and lookup stage registers fill. Configuration writes are
// always ready and take effect at once; write them only while the block is idle.

module perceptron_delta_rule_trainer_top import pdrt_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // op[1:0], pattern[5:2], target[6], zero[7]
  input  logic                   s_axis_tlast,  // last_in_epoch
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [23:0]            m_axis_tdata,  // predicted[0], mismatch[1], epoch_errors[9:2],
                                                // epoch_number[15:10], train_status[17:16], zero[23:18]
  output logic                   m_axis_tlast,  // epoch_done
  // configuration writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [0:0]             cfg_index,
  input  logic [LR_BITS-1:0]     cfg_data
);

  localparam int OUT_USED = 2 + ERR_BITS + EPOCH_BITS + STAT_BITS;

  // configuration registers
  logic [LR_BITS-1:0]    learning_rate;
  logic [EPOCH_BITS-1:0] max_epochs;

  // input register
  logic                  s0_valid;
  logic [OP_BITS-1:0]    s0_op;
  logic [INPUT_BITS-1:0] s0_pattern;
  logic                  s0_target;
  logic                  s0_last;

  // lookup stage register
  logic                  s1_valid;
  logic [OP_BITS-1:0]    s1_op;
  logic [INPUT_BITS-1:0] s1_pattern;
  logic                  s1_target;
  logic                  s1_last;
  logic                  s1_pred;
  logic                  s1_mis;
  logic [ENTRY_BITS-1:0] s1_entry;

  // training state
  logic [ERR_BITS-1:0]   error_count;
  logic [EPOCH_BITS-1:0] epoch_count;
  logic [STAT_BITS-1:0]  status_reg;
  logic [ERR_BITS-1:0]   error_count_next;
  logic [EPOCH_BITS-1:0] epoch_count_next;
  logic [STAT_BITS-1:0]  status_reg_next;

  // output register
  logic                  out_valid;
  logic                  out_pred;
  logic                  out_mis;
  logic                  out_done;
  logic [ERR_BITS-1:0]   out_errors;
  logic [EPOCH_BITS-1:0] out_epoch;
  logic [STAT_BITS-1:0]  out_status;

  // lookup stage logic
  logic signed [NET_BITS-1:0] net;
  logic [NET_BITS-1:0]        net_mag;
  logic [NET_BITS-1:0]        net_scaled;
  logic [IDX_BITS-1:0]        deriv_idx;
  logic                       a_pred;
  logic                       a_mis;

  // update stage logic
  logic                       s1_hazard;
  logic                       a_adv;
  logic                       b_adv;
  logic                       train_live;
  logic [PROD_BITS-1:0]       prod;
  logic [PROD_BITS:0]         prod_round;
  logic [STEP_BITS-1:0]       step;
  logic [ERR_BITS-1:0]        err_inc;
  logic [ERR_BITS-1:0]        b_errors;
  logic [EPOCH_BITS-1:0]      b_epoch;
  logic                       b_done;
  wupd_t                      upd;

  // ---------------------------------------------------------------------------
  // Configuration: always ready, write by register index
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= LR_RESET;
      max_epochs    <= EPOCHS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LEARNING_RATE: learning_rate <= cfg_data;
        CFG_MAX_EPOCHS:    max_epochs    <= cfg_data[EPOCH_BITS-1:0];
        default:           ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Flow control. The item in the update stage changes the weights when it is a
  // clear or a live mismatching train; hold the lookup stage until it has left.
  assign s1_hazard = (s1_op == OP_CLEAR) ||
                     ((s1_op == OP_TRAIN) && s1_mis && (status_reg == STAT_RUNNING));
  assign b_adv     = s1_valid && (!out_valid || m_axis_tready);
  assign a_adv     = s0_valid && (!s1_valid || (b_adv && !s1_hazard));
  assign s_axis_tready = !s0_valid || a_adv;

  // ---------------------------------------------------------------------------
  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s0_op      <= s_axis_tdata[OP_BITS-1:0];
      s0_pattern <= s_axis_tdata[OP_BITS +: INPUT_BITS];
      s0_target  <= s_axis_tdata[OP_BITS + INPUT_BITS];
      s0_last    <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup stage: net sum, prediction and derivative index clamped to the table
  pdrt_weights u_weights (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .rd_pattern (s0_pattern),
    .net        (net)
  );

  assign a_pred     = !net[NET_BITS-1];
  assign a_mis      = (s0_op == OP_TRAIN) && (a_pred != s0_target);
  assign net_mag    = net[NET_BITS-1] ? NET_BITS'(-net) : NET_BITS'(net);
  assign net_scaled = net_mag >> IDX_SHIFT;
  assign deriv_idx  = (64'(net_scaled) > 64'(DERIV_DEPTH - 1)) ?
                      IDX_BITS'(DERIV_DEPTH - 1) : IDX_BITS'(net_scaled);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (a_adv) begin
      s1_valid <= 1'b1;
    end else if (b_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      s1_op      <= s0_op;
      s1_pattern <= s0_pattern;
      s1_target  <= s0_target;
      s1_last    <= s0_last;
      s1_pred    <= a_pred;
      s1_mis     <= a_mis;
      s1_entry   <= DERIV_ROM[deriv_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Update stage: step = round(rate * derivative) in Q.8, then counters
  assign prod       = PROD_BITS'(learning_rate) * PROD_BITS'(s1_entry);
  assign prod_round = {1'b0, prod} + (PROD_BITS + 1)'(1 << (FRAC_SHIFT - 1));
  assign step       = prod_round[PROD_BITS:FRAC_SHIFT];
  assign train_live = (s1_op == OP_TRAIN) && (status_reg == STAT_RUNNING);
  assign err_inc    = (s1_mis && (error_count != '1)) ? error_count + ERR_BITS'(1)
                                                      : error_count;

  always_comb begin
    upd.apply    = b_adv && train_live && s1_mis;
    upd.clear    = b_adv && (s1_op == OP_CLEAR);
    upd.increase = s1_target;
    upd.pattern  = s1_pattern;
    upd.step     = step;
  end

  always_comb begin
    error_count_next = error_count;
    epoch_count_next = epoch_count;
    status_reg_next  = status_reg;
    b_errors         = error_count;
    b_epoch          = epoch_count;
    b_done           = 1'b0;
    if (s1_op == OP_CLEAR) begin
      error_count_next = '0;
      epoch_count_next = '0;
      status_reg_next  = STAT_RUNNING;
      b_errors         = '0;
      b_epoch          = '0;
    end else if (train_live) begin
      b_errors         = err_inc;
      error_count_next = err_inc;
      if (s1_last) begin
        // close the epoch: converged, give up, or advance the epoch number
        b_done           = 1'b1;
        error_count_next = '0;
        if (err_inc == '0) begin
          status_reg_next = STAT_CONVERGED;
        end else if (epoch_count >= max_epochs) begin
          status_reg_next = STAT_GAVE_UP;
        end else if (epoch_count != '1) begin
          epoch_count_next = epoch_count + EPOCH_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_count <= '0;
      epoch_count <= '0;
      status_reg  <= STAT_RUNNING;
    end else if (b_adv) begin
      error_count <= error_count_next;
      epoch_count <= epoch_count_next;
      status_reg  <= status_reg_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      out_pred   <= s1_pred;
      out_mis    <= s1_mis;
      out_done   <= b_done;
      out_errors <= b_errors;
      out_epoch  <= b_epoch;
      out_status <= status_reg_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_done;
  assign m_axis_tdata  = {(24 - OUT_USED)'(0), out_status, out_epoch, out_errors,
                          out_mis, out_pred};

  // ---------------------------------------------------------------------------
  // Assertions

  // A finished run stays finished until a clear passes the update stage
  a_status_sticky: assert property (@(posedge clk) disable iff (rst)
    (status_reg != STAT_RUNNING) && !(b_adv && (s1_op == OP_CLEAR))
    |=> status_reg == $past(status_reg))
    else $error("training status left a finished state without a clear");

  // The epoch number only steps by one or returns to zero
  a_epoch_step: assert property (@(posedge clk) disable iff (rst)
    epoch_count != $past(epoch_count)
    |-> (epoch_count == EPOCH_BITS'($past(epoch_count) + 1'b1)) || (epoch_count == '0))
    else $error("epoch counter jumped");

  // Closing an epoch always restarts the error count
  a_epoch_close: assert property (@(posedge clk) disable iff (rst)
    b_adv && b_done |=> error_count == '0)
    else $error("error count not cleared at end of epoch");

  // No item enters the update stage behind one that is still changing the weights
  a_no_stale_net: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_hazard && !b_adv |=> s1_valid && $stable(s1_pattern) && $stable(s1_op))
    else $error("update stage item overwritten before its weight update");

endmodule

[design/pdrt_weights.sv]
// Weight bank of the perceptron trainer: weights and bias, net input sum and
// the saturating delta-rule update. Depends on pdrt_pkg.
module pdrt_weights import pdrt_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  wupd_t                      upd,
  input  logic [INPUT_BITS-1:0]      rd_pattern,
  output logic signed [NET_BITS-1:0] net
);

  localparam logic signed [ACC_BITS-1:0] W_MAX = ACC_BITS'((64'sd1 <<< (WEIGHT_BITS - 1)) - 1);
  localparam logic signed [ACC_BITS-1:0] W_MIN = -W_MAX - ACC_BITS'(1);

  logic signed [WEIGHT_BITS-1:0] weights      [NUM_WEIGHTS];
  logic signed [WEIGHT_BITS-1:0] weights_next [NUM_WEIGHTS];
  logic        [NUM_WEIGHTS-1:0] active;
  logic signed [ACC_BITS-1:0]    delta_mag;
  logic signed [ACC_BITS-1:0]    delta;

  // Bias sits at the top index and always counts
  always_comb begin
    net = NET_BITS'(weights[INPUT_BITS]);
    for (int i = 0; i < INPUT_BITS; i++) begin
      if (rd_pattern[i]) net = net + NET_BITS'(weights[i]);
    end
  end

  assign active    = {1'b1, upd.pattern};
  assign delta_mag = ACC_BITS'(upd.step);
  assign delta     = upd.increase ? delta_mag : -delta_mag;

  always_comb begin
    logic signed [ACC_BITS-1:0] sum;
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      sum = ACC_BITS'(weights[i]) + delta;
      if (!active[i])      weights_next[i] = weights[i];
      else if (sum > W_MAX) weights_next[i] = WEIGHT_BITS'(W_MAX);
      else if (sum < W_MIN) weights_next[i] = WEIGHT_BITS'(W_MIN);
      else                  weights_next[i] = WEIGHT_BITS'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || upd.clear) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) weights[i] <= '0;
    end else if (upd.apply) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) weights[i] <= weights_next[i];
    end
  end

endmodule

[tb/sv/tb_perceptron_delta_rule_trainer_top.sv]
// Self-checking testbench for perceptron_delta_rule_trainer_top: directed table, then
// randomised training phases, checked against a cycle-free predictor or typed rows.
// Depends on pdrt_pkg and perceptron_delta_rule_trainer_top.
`timescale 1ns / 1ps

module tb_perceptron_delta_rule_trainer_top;
  import pdrt_pkg::*;

  // Unused op code: the block treats it as classify
  localparam logic [OP_BITS-1:0] OP_UNUSED = OP_BITS'(3);

  localparam int ITEM_TARGET   = 1600;   // requests to offer in total
  localparam int QUIET_FROM    = 1350;   // from here on neither side idles
  localparam int DRAIN_CYCLES  = 16;     // settle time after the last result
  localparam int LONG_HOLD_AT  = 400;    // results taken before the long receiver hold-off
  localparam int WEIGHT_MAX    = 2 ** (WEIGHT_BITS - 1) - 1;
  localparam int WEIGHT_MIN    = -WEIGHT_MAX - 1;
  localparam int ERR_MAX       = 2 ** ERR_BITS - 1;
  localparam int EPOCH_MAX     = 2 ** EPOCH_BITS - 1;

  // One result, field by field
  typedef struct packed {
    logic                  predicted;
    logic                  mismatch;
    logic                  epoch_done;
    logic [ERR_BITS-1:0]   epoch_errors;
    logic [EPOCH_BITS-1:0] epoch_number;
    logic [STAT_BITS-1:0]  train_status;
  } outcome_t;

  // One row of the directed table; set_regs writes rate and cap before the request
  typedef struct {
    bit                    set_regs;
    logic [LR_BITS-1:0]    rate;
    logic [EPOCH_BITS-1:0] cap;
    logic [OP_BITS-1:0]    op;
    logic [INPUT_BITS-1:0] pattern;
    logic                  target;
    logic                  last;
    bit                    typed;
    outcome_t              want;
  } stim_row_t;

  localparam outcome_t NO_OUTCOME = '0;
  localparam int       DIRECTED_ROWS = 23;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata = '0;   // op[1:0], pattern[5:2], target[6], zero[7]
  logic                   s_axis_tlast = 1'b0; // last_in_epoch
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [23:0]            m_axis_tdata;        // predicted[0], mismatch[1], epoch_errors[9:2],
                                               // epoch_number[15:10], train_status[17:16]
  logic                   m_axis_tlast;        // epoch_done
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [0:0]             cfg_index = '0;
  logic [LR_BITS-1:0]     cfg_data = '0;

  // Typed expectation travelling alongside the request on the bus
  bit                     req_typed = 1'b0;
  outcome_t               req_want = '0;

  // Predictor state: weights 0..3 then bias, counters, status and registers
  logic signed [WEIGHT_BITS-1:0] neuron_w [NUM_WEIGHTS];
  int unsigned            err_tally = 0;
  int unsigned            epoch_tally = 0;
  logic [STAT_BITS-1:0]   run_status = STAT_RUNNING;
  logic [LR_BITS-1:0]     step_rate = LR_RESET;
  logic [EPOCH_BITS-1:0]  epoch_cap = EPOCHS_RESET;
  longint unsigned        sech_tab [DERIV_DEPTH];

  outcome_t               pending_outcomes [$];
  int                     items_sent = 0;
  int                     results_seen = 0;
  int                     fault_count = 0;

  perceptron_delta_rule_trainer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Build the 0.5*sech^2 table in Q0.16 from the exp(-2x) recurrence, and zero the weights
  initial begin
    longint unsigned r;
    r = 64'd65536;
    for (int i = 0; i < DERIV_DEPTH; i++) begin
      sech_tab[i] = ((2 * r) << 32) / ((64'd65536 + r) * (64'd65536 + r));
      r = (r * 64'd57835 + 64'd32768) >> 16;
    end
    for (int i = 0; i < NUM_WEIGHTS; i++) neuron_w[i] = '0;
  end

  // Advance the neuron by one request and return the result it should give
  function automatic outcome_t train_neuron(logic [OP_BITS-1:0] op,
                                            logic [INPUT_BITS-1:0] pat,
                                            logic tgt, logic last);
    int              net;
    int              mag;
    int              idx;
    int              nudge;
    int              nxt;
    longint unsigned step;
    outcome_t        o;
    net = int'(neuron_w[INPUT_BITS]);
    for (int i = 0; i < INPUT_BITS; i++)
      if (pat[i]) net += int'(neuron_w[i]);
    o = '0;
    o.predicted = (net >= 0);
    o.mismatch  = (op == OP_TRAIN) && (o.predicted != tgt);
    o.epoch_errors = ERR_BITS'(err_tally);
    o.epoch_number = EPOCH_BITS'(epoch_tally);
    if (op == OP_CLEAR) begin
      // wipe weights, counters and status; registers survive
      for (int i = 0; i < NUM_WEIGHTS; i++) neuron_w[i] = '0;
      err_tally   = 0;
      epoch_tally = 0;
      run_status  = STAT_RUNNING;
      o.epoch_errors = '0;
      o.epoch_number = '0;
    end else if (op == OP_TRAIN && run_status == STAT_RUNNING) begin
      if (o.mismatch) begin
        mag = (net < 0) ? -net : net;
        idx = mag >> IDX_SHIFT;
        if (idx > DERIV_DEPTH - 1) idx = DERIV_DEPTH - 1;
        step  = (longint'(step_rate) * sech_tab[idx] + 64'd32768) >> 16;
        nudge = tgt ? int'(step) : -int'(step);
        for (int i = 0; i < NUM_WEIGHTS; i++) begin
          if (i == INPUT_BITS || pat[i]) begin
            nxt = int'(neuron_w[i]) + nudge;
            if (nxt > WEIGHT_MAX) nxt = WEIGHT_MAX;
            if (nxt < WEIGHT_MIN) nxt = WEIGHT_MIN;
            neuron_w[i] = nxt[WEIGHT_BITS-1:0];
          end
        end
        if (err_tally < ERR_MAX) err_tally++;
      end
      o.epoch_errors = ERR_BITS'(err_tally);
      o.epoch_number = EPOCH_BITS'(epoch_tally);
      if (last) begin
        o.epoch_done = 1'b1;
        if (err_tally == 0) run_status = STAT_CONVERGED;
        else if (epoch_tally >= epoch_cap) run_status = STAT_GAVE_UP;
        else if (epoch_tally < EPOCH_MAX) epoch_tally++;
        err_tally = 0;
      end
    end
    o.train_status = run_status;
    return o;
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    $display("result %0d: %s is %0d, expected %0d", results_seen, field, got, want);
    fault_count++;
  endtask

  // Monitor: check taken results first (they are always older), then log new requests
  always @(posedge clk) begin
    outcome_t got;
    outcome_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.predicted    = m_axis_tdata[0];
        got.mismatch     = m_axis_tdata[1];
        got.epoch_errors = m_axis_tdata[9:2];
        got.epoch_number = m_axis_tdata[15:10];
        got.train_status = m_axis_tdata[17:16];
        got.epoch_done   = m_axis_tlast;
        if (pending_outcomes.size() == 0) begin
          flag_mismatch("result with no request pending", int'(m_axis_tdata), 0);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.predicted !== want.predicted)
            flag_mismatch("predicted", got.predicted, want.predicted);
          if (got.mismatch !== want.mismatch)
            flag_mismatch("mismatch", got.mismatch, want.mismatch);
          if (got.epoch_done !== want.epoch_done)
            flag_mismatch("epoch_done", got.epoch_done, want.epoch_done);
          if (got.epoch_errors !== want.epoch_errors)
            flag_mismatch("epoch_errors", got.epoch_errors, want.epoch_errors);
          if (got.epoch_number !== want.epoch_number)
            flag_mismatch("epoch_number", got.epoch_number, want.epoch_number);
          if (got.train_status !== want.train_status)
            flag_mismatch("train_status", got.train_status, want.train_status);
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LEARNING_RATE) step_rate = cfg_data;
        else if (cfg_index == CFG_MAX_EPOCHS) epoch_cap = cfg_data[EPOCH_BITS-1:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = train_neuron(s_axis_tdata[1:0], s_axis_tdata[5:2], s_axis_tdata[6],
                            s_axis_tlast);
        // a typed row overrides the predictor, which still advances its state
        if (req_typed) want = req_want;
        pending_outcomes.insert(pending_outcomes.size(), want);
      end
    end
  end

  // Offer one request; drop valid for a random burst first when idling is on
  task automatic send_req(logic [OP_BITS-1:0] op, logic [INPUT_BITS-1:0] pat,
                          logic tgt, logic last, bit typed, outcome_t want);
    if (items_sent < QUIET_FROM && (items_sent / 150) % 3 != 2 &&
        $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, tgt, pat, op};
    s_axis_tlast  <= last;
    req_typed     <= typed;
    req_want      <= want;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  // Write both registers once every request has come back and the pipeline is empty
  task automatic write_regs(logic [LR_BITS-1:0] rate, logic [EPOCH_BITS-1:0] cap);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_LEARNING_RATE;
    cfg_data  <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_MAX_EPOCHS;
    cfg_data  <= LR_BITS'(cap);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts, stretches without stalls, and one long hold-off,
  // started while a request is on offer, so that the block backs up and stalls its
  // request side
  initial begin
    int hold;
    bit long_hold_done;
    hold = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AT && s_axis_tvalid) begin
        long_hold_done = 1'b1;
        hold = 250;
        m_axis_tready <= 1'b0;
      end else if (items_sent < QUIET_FROM && (results_seen / 120) % 3 != 2 &&
                   $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(0, 9);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Directed requests. Typed results are the ones that follow straight from the rules:
  // zero weights fire, the first miss at rate 1.0 moves the bias by 128, a full-rate
  // miss moves by 2048, and rate zero never moves anything.
  stim_row_t directed [DIRECTED_ROWS] = '{
    // after reset: classify, the unused op, and a matching train request
    '{1'b0, 12'd0, 6'd0, OP_CLASSIFY, 4'h0, 1'b0, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 8'd0, 6'd0, STAT_RUNNING}},
    '{1'b0, 12'd0, 6'd0, OP_UNUSED,   4'hF, 1'b1, 1'b1, 1'b1,
      '{1'b1, 1'b0, 1'b0, 8'd0, 6'd0, STAT_RUNNING}},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'hF, 1'b1, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 8'd0, 6'd0, STAT_RUNNING}},
    // two misses, the second closes epoch 0
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'h0, 1'b0, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b0, 8'd1, 6'd0, STAT_RUNNING}},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'h0, 1'b1, 1'b1, 1'b1,
      '{1'b0, 1'b1, 1'b1, 8'd2, 6'd0, STAT_RUNNING}},
    '{1'b0, 12'd0, 6'd0, OP_CLASSIFY, 4'h0, 1'b1, 1'b0, 1'b0, NO_OUTCOME},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'hA, 1'b0, 1'b0, 1'b0, NO_OUTCOME},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'h5, 1'b1, 1'b1, 1'b0, NO_OUTCOME},
    '{1'b0, 12'd0, 6'd0, OP_CLEAR,    4'hF, 1'b1, 1'b1, 1'b0, NO_OUTCOME},
    // an error-free epoch converges; later train requests are reported but ignored
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'hF, 1'b1, 1'b1, 1'b1,
      '{1'b1, 1'b0, 1'b1, 8'd0, 6'd0, STAT_CONVERGED}},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'h0, 1'b0, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b0, 8'd0, 6'd0, STAT_CONVERGED}},
    '{1'b0, 12'd0, 6'd0, OP_CLASSIFY, 4'h5, 1'b0, 1'b1, 1'b1,
      '{1'b1, 1'b0, 1'b0, 8'd0, 6'd0, STAT_CONVERGED}},
    '{1'b0, 12'd0, 6'd0, OP_CLEAR,    4'h0, 1'b0, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 8'd0, 6'd0, STAT_RUNNING}},
    // full rate, cap 0: one missed epoch gives up at once
    '{1'b1, 12'd4095, 6'd0, OP_TRAIN, 4'h3, 1'b0, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 8'd1, 6'd0, STAT_GAVE_UP}},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'h3, 1'b1, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 8'd0, 6'd0, STAT_GAVE_UP}},
    '{1'b0, 12'd0, 6'd0, OP_CLASSIFY, 4'h1, 1'b0, 1'b0, 1'b0, NO_OUTCOME},
    '{1'b0, 12'd0, 6'd0, OP_CLEAR,    4'hC, 1'b0, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b0, 8'd0, 6'd0, STAT_RUNNING}},
    // rate zero, cap 63: misses count but weights stay put
    '{1'b1, 12'd0, 6'd63, OP_TRAIN,   4'h6, 1'b0, 1'b1, 1'b1,
      '{1'b1, 1'b1, 1'b1, 8'd1, 6'd0, STAT_RUNNING}},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'h9, 1'b0, 1'b0, 1'b1,
      '{1'b1, 1'b1, 1'b0, 8'd1, 6'd1, STAT_RUNNING}},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'hF, 1'b1, 1'b1, 1'b1,
      '{1'b1, 1'b0, 1'b1, 8'd1, 6'd1, STAT_RUNNING}},
    // back to the reset registers
    '{1'b1, 12'd256, 6'd40, OP_CLEAR, 4'h0, 1'b0, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 8'd0, 6'd0, STAT_RUNNING}},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'h1, 1'b0, 1'b0, 1'b0, NO_OUTCOME},
    '{1'b0, 12'd0, 6'd0, OP_TRAIN,    4'h2, 1'b0, 1'b1, 1'b0, NO_OUTCOME}
  };

  // Main stimulus: reset, directed table, then random training phases
  initial begin
    logic [LR_BITS-1:0]    rate;
    logic [EPOCH_BITS-1:0] cap;
    logic [15:0]           truth;
    logic [INPUT_BITS-1:0] mask;
    logic [INPUT_BITS-1:0] train_set [8];
    int                    set_size;
    int                    epochs;
    int                    thr;
    int                    pick;
    int                    phase;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      if (directed[r].set_regs) write_regs(directed[r].rate, directed[r].cap);
      send_req(directed[r].op, directed[r].pattern, directed[r].target, directed[r].last,
               directed[r].typed, directed[r].want);
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      // pick the registers for this phase, extremes included
      case ($urandom_range(0, 5))
        0:       rate = '0;
        1:       rate = '1;
        2, 3:    rate = LR_RESET;
        default: rate = LR_BITS'($urandom_range(16, 1024));
      endcase
      case ($urandom_range(0, 4))
        0:       cap = '0;
        1:       cap = '1;
        default: cap = EPOCH_BITS'($urandom_range(2, 40));
      endcase
      if (phase == 3) rate = '0;
      if (phase == 6) begin
        rate = '0;
        cap  = '1;
      end
      write_regs(rate, cap);
      send_req(OP_CLEAR, INPUT_BITS'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_OUTCOME);

      if (phase == 3) begin
        // one long epoch of misses: frozen zero weights fire, every target is 0,
        // so the error count runs into its ceiling
        for (int n = 0; n < 300; n++)
          send_req(OP_TRAIN, INPUT_BITS'($urandom), 1'b0, n == 299, 1'b0, NO_OUTCOME);
      end else if (phase == 6) begin
        // one missed request per epoch walks the epoch counter up to 63, then gives up
        for (int n = 0; n < 66; n++)
          send_req(OP_TRAIN, INPUT_BITS'($urandom), 1'b0, 1'b1, 1'b0, NO_OUTCOME);
      end else begin
        // training set with targets from a truth table: threshold, single bit or random
        case ($urandom_range(0, 2))
          0: begin
            mask = INPUT_BITS'($urandom_range(1, 15));
            thr  = $urandom_range(0, $countones(mask));
            for (int p = 0; p < 16; p++)
              truth[p] = ($countones(INPUT_BITS'(p) & mask) >= thr);
          end
          1: begin
            pick = $urandom_range(0, INPUT_BITS - 1);
            for (int p = 0; p < 16; p++) truth[p] = 1'(INPUT_BITS'(p) >> pick);
          end
          default: truth = 16'($urandom);
        endcase
        set_size = $urandom_range(1, 8);
        for (int k = 0; k < set_size; k++) train_set[k] = INPUT_BITS'($urandom);
        epochs = $urandom_range(1, 14);
        for (int e = 0; e < epochs; e++) begin
          for (int k = 0; k < set_size; k++) begin
            pick = $urandom_range(0, 59);
            // slip in a classify, or a fully random request, now and then
            if (pick < 3)
              send_req((pick == 0) ? OP_UNUSED : OP_CLASSIFY, INPUT_BITS'($urandom),
                       1'($urandom), 1'($urandom), 1'b0, NO_OUTCOME);
            else if (pick == 3)
              send_req(OP_BITS'($urandom), INPUT_BITS'($urandom), 1'($urandom),
                       1'($urandom), 1'b0, NO_OUTCOME);
            send_req(OP_TRAIN, train_set[k], truth[train_set[k]], k == set_size - 1,
                     1'b0, NO_OUTCOME);
          end
        end
      end
    end

    // drain: wait for every outstanding result, then let the pipeline settle
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_outcomes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[perceptron_delta_rule_trainer_top.f]
design/pdrt_pkg.sv
design/pdrt_weights.sv
design/perceptron_delta_rule_trainer_top.sv
tb/sv/tb_perceptron_delta_rule_trainer_top.sv
